// File: design/id3tu_pkg.sv
`default_nettype none
package id3tu_pkg;

  localparam logic [1:0] MODE_LATIN1  = 2'd0;
  localparam logic [1:0] MODE_U16_BOM = 2'd1;
  localparam logic [1:0] MODE_U16_BE  = 2'd2;
  localparam logic [1:0] MODE_UTF8    = 2'd3;

  localparam logic [7:0] ENC_U16_BOM  = 8'd1;
  localparam logic [7:0] ENC_U16_BE   = 8'd2;
  localparam logic [7:0] ENC_UTF8     = 8'd3;

  localparam logic [7:0] BOM_HI       = 8'hFF;
  localparam logic [7:0] BOM_LO       = 8'hFE;
  localparam logic [7:0] CAP_RESET    = 8'd128;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // one accepted item's worth of output: up to three text bytes and a NUL
  typedef struct packed {
    logic [2:0][7:0] text;
    logic [1:0]      nbytes;
    logic            term;
  } job_t;

endpackage
`default_nettype wire

// File: design/id3tu_front.sv
`default_nettype none
module id3tu_front (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic cfg_wr_en,
  input  wire                logic [7:0] cfg_wr_data,
  input  wire                logic in_valid,
  output logic               in_ready,
  input  wire                logic [7:0] in_encoding,
  input  wire                logic [7:0] in_data_byte,
  input  wire                logic in_has_byte,
  input  wire                logic in_first_byte,
  input  wire                logic in_last_byte,
  input  wire                logic q_full,
  output logic               push,
  output id3tu_pkg::job_t    push_job
);
  import id3tu_pkg::*;

  logic [7:0]  cap_r;
  logic [1:0]  mode_r, mode_e, mode_nxt;
  logic        be_r, be_e, be_nxt;
  logic        half_r, half_e, half_nxt;
  logic [7:0]  held_r, held_e, held_nxt;
  logic        fp_r, fp_e, fp_nxt;
  logic        stop_r, stop_e, stop_nxt;
  logic [7:0]  bw_r, bw_e, bw_nxt;
  logic [7:0]  limit;
  logic [15:0] cp;
  logic        emit_cp;
  logic [1:0]  len;
  logic [8:0]  bw_sum;
  logic        accept;
  job_t        job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign limit    = (cap_r == 8'd0) ? 8'd0 : cap_r - 8'd1;

  always_comb begin
    mode_e = mode_r;
    be_e   = be_r;
    half_e = half_r;
    held_e = held_r;
    fp_e   = fp_r;
    stop_e = stop_r;
    bw_e   = bw_r;
    if (in_first_byte) begin
      mode_e = (in_encoding == ENC_U16_BOM || in_encoding == ENC_U16_BE ||
                in_encoding == ENC_UTF8) ? in_encoding[1:0] : MODE_LATIN1;
      be_e   = (in_encoding == ENC_U16_BE);
      half_e = 1'b0;
      held_e = 8'd0;
      fp_e   = 1'b1;
      stop_e = 1'b0;
      bw_e   = 8'd0;
    end
    mode_nxt = mode_e;
    be_nxt   = be_e;
    half_nxt = half_e;
    held_nxt = held_e;
    fp_nxt   = fp_e;
    stop_nxt = stop_e;
    bw_nxt   = bw_e;
    job      = '0;
    cp       = 16'd0;
    emit_cp  = 1'b0;
    len      = 2'd1;
    bw_sum   = 9'd0;

    if (in_has_byte && !stop_e) begin
      unique case (mode_e)
        MODE_U16_BOM, MODE_U16_BE: begin
          if (!half_e) begin
            held_nxt = in_data_byte;
            half_nxt = 1'b1;
          end else begin
            half_nxt = 1'b0;
            fp_nxt   = 1'b0;
            cp = be_e ? {held_e, in_data_byte} : {in_data_byte, held_e};
            if (mode_e == MODE_U16_BOM && fp_e &&
                held_e == BOM_HI && in_data_byte == BOM_LO) begin
              be_nxt = 1'b0;
            end else if (mode_e == MODE_U16_BOM && fp_e &&
                         held_e == BOM_LO && in_data_byte == BOM_HI) begin
              be_nxt = 1'b1;
            end else if (cp == 16'd0) begin
              stop_nxt = 1'b1;
            end else begin
              emit_cp = 1'b1;
            end
          end
        end
        MODE_UTF8: begin
          if (in_data_byte == 8'd0 || bw_e >= limit) begin
            stop_nxt = 1'b1;
          end else begin
            job.text[0] = in_data_byte;
            job.nbytes  = 2'd1;
            bw_nxt      = bw_e + 8'd1;
          end
        end
        default: begin
          if (in_data_byte == 8'd0) begin
            stop_nxt = 1'b1;
          end else begin
            cp      = {8'd0, in_data_byte};
            emit_cp = 1'b1;
          end
        end
      endcase
    end

    if (emit_cp) begin
      if (cp < 16'h0080)      len = 2'd1;
      else if (cp < 16'h0800) len = 2'd2;
      else                    len = 2'd3;
      bw_sum = {1'b0, bw_e} + {7'd0, len};
      if (bw_sum <= {1'b0, limit}) begin
        bw_nxt     = bw_sum[7:0];
        job.nbytes = len;
        unique case (len)
          2'd1: job.text[0] = cp[7:0];
          2'd2: begin
            job.text[0] = {3'b110, cp[10:6]};
            job.text[1] = {2'b10, cp[5:0]};
          end
          default: begin
            job.text[0] = {4'b1110, cp[15:12]};
            job.text[1] = {2'b10, cp[11:6]};
            job.text[2] = {2'b10, cp[5:0]};
          end
        endcase
      end
    end

    if (in_last_byte) begin
      half_nxt = 1'b0;
      stop_nxt = 1'b1;
      job.term = 1'b1;
    end
  end

  assign push     = accept && (job.nbytes != 2'd0 || job.term);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      mode_r <= MODE_LATIN1;
      be_r   <= 1'b0;
      half_r <= 1'b0;
      held_r <= 8'd0;
      fp_r   <= 1'b1;
      stop_r <= 1'b0;
      bw_r   <= 8'd0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (accept) begin
        mode_r <= mode_nxt;
        be_r   <= be_nxt;
        half_r <= half_nxt;
        held_r <= held_nxt;
        fp_r   <= fp_nxt;
        stop_r <= stop_nxt;
        bw_r   <= bw_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/id3tu_queue.sv
`default_nettype none
module id3tu_queue (
  input  wire             logic clk,
  input  wire             logic rst_n,
  input  wire             logic push,
  input  id3tu_pkg::job_t push_job,
  output logic            full,
  input  wire             logic pop,
  output logic            empty,
  output id3tu_pkg::job_t head
);
  import id3tu_pkg::*;

  job_t           slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r;
  logic           do_push, do_pop;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + (QAW+1)'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - (QAW+1)'(1);
    end
  end

endmodule
`default_nettype wire

// File: design/id3tu_back.sv
`default_nettype none
module id3tu_back (
  input  wire             logic clk,
  input  wire             logic rst_n,
  input  wire             logic q_empty,
  input  id3tu_pkg::job_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  wire             logic out_ready,
  output logic [7:0]      out_byte,
  output logic            out_is_terminator,
  output logic            out_run_last
);
  import id3tu_pkg::*;

  job_t       cur_r;
  logic       cur_vld_r;
  logic [1:0] idx_r;
  logic       ovld_r;
  logic [7:0] obyte_r;
  logic       oterm_r, olast_r;
  logic       advance, move, cur_last, take;
  logic [2:0] total;
  logic [7:0] sel_byte;
  logic       sel_term;

  assign advance  = !ovld_r || out_ready;
  assign move     = advance && cur_vld_r;
  assign total    = {1'b0, cur_r.nbytes} + {2'b00, cur_r.term};
  assign cur_last = ({1'b0, idx_r} == total - 3'd1);
  assign take     = !cur_vld_r || (move && cur_last);
  assign q_pop    = take && !q_empty;
  assign sel_term = (idx_r >= cur_r.nbytes);
  assign sel_byte = sel_term ? 8'd0 : cur_r.text[idx_r];

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
    if (move) begin
      obyte_r <= sel_byte;
      oterm_r <= sel_term;
      olast_r <= cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= 2'd0;
      ovld_r    <= 1'b0;
    end else begin
      if (advance) ovld_r <= cur_vld_r;
      if (q_pop) begin
        cur_vld_r <= 1'b1;
        idx_r     <= 2'd0;
      end else if (take) begin
        cur_vld_r <= 1'b0;
      end else if (move) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  assign out_valid         = ovld_r;
  assign out_byte          = obyte_r;
  assign out_is_terminator = oterm_r;
  assign out_run_last      = olast_r;

endmodule
`default_nettype wire

// File: design/id3_text_to_utf8_unit.sv
// Transcoder for the body of an ID3 text field into a capped UTF-8 string.
// Input channel (in_*): one raw body byte a beat, with the encoding code,
// first/last markers and a has-byte flag for an empty body. A beat may be
// taken every cycle while the two-entry job queue has room.
// Output channel (out_*): one UTF-8 byte a beat; the closing NUL carries
// out_is_terminator and the final byte caused by an input beat carries
// out_run_last. An input beat causes 0 to 4 output beats.
// The bytes of a beat pass through the job queue, the current-job register
// and the output register. Throughput is one output byte a cycle while
// out_ready is high, set by the single-byte output register.
// cfg_wr_en/cfg_wr_data write text_capacity (bytes, NUL included) at once;
// write only while the block is idle.
// Reset (rst_n low, synchronous) empties the queue, sets Latin-1 mode and a
// capacity of 128. When out_ready is low the output byte holds, the queue
// fills, and in_ready drops until room returns.
`default_nettype none
module id3_text_to_utf8_unit (
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  logic cfg_wr_en,
  input  wire  logic [7:0] cfg_wr_data,
  input  wire  logic in_valid,
  output logic in_ready,
  input  wire  logic [7:0] in_encoding,
  input  wire  logic [7:0] in_data_byte,
  input  wire  logic in_has_byte,
  input  wire  logic in_first_byte,
  input  wire  logic in_last_byte,
  output logic out_valid,
  input  wire  logic out_ready,
  output logic [7:0] out_byte,
  output logic out_is_terminator,
  output logic out_run_last
);
  import id3tu_pkg::*;

  logic push, pop, q_full, q_empty;
  job_t push_job, q_head;

  id3tu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_encoding   (in_encoding),
    .in_data_byte  (in_data_byte),
    .in_has_byte   (in_has_byte),
    .in_first_byte (in_first_byte),
    .in_last_byte  (in_last_byte),
    .q_full        (q_full),
    .push          (push),
    .push_job      (push_job)
  );

  id3tu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  id3tu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_is_terminator (out_is_terminator),
    .out_run_last      (out_run_last)
  );

endmodule
`default_nettype wire

// File: tb/id3_text_to_utf8_unit_test.sv
`timescale 1ns / 1ps
module id3_text_to_utf8_unit_test;
  import id3tu_pkg::*;

  localparam logic [7:0] ENC_LATIN1 = 8'd0;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SEGMENT_BEATS = 52;
  localparam int unsigned LONG_HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] enc;
    logic [7:0] body_byte;
    logic       has_byte;
    logic       first_mark;
    logic       last_mark;
  } text_beat_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       term;
    logic       ends_run;
  } utf8_beat_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_encoding = 8'd0;
  logic [7:0] in_data_byte = 8'd0;
  logic in_has_byte = 1'b0;
  logic in_first_byte = 1'b0;
  logic in_last_byte = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_byte;
  logic out_is_terminator;
  logic out_run_last;

  id3_text_to_utf8_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_encoding      (in_encoding),
    .in_data_byte     (in_data_byte),
    .in_has_byte      (in_has_byte),
    .in_first_byte    (in_first_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_is_terminator(out_is_terminator),
    .out_run_last     (out_run_last)
  );

  text_beat_t text_beats_pending[$];
  utf8_beat_t utf8_due[$];
  utf8_beat_t step_out[$];

  int unsigned beats_queued = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic in_fire = 1'b0;
  logic want_long_hold = 1'b0;
  logic long_hold_done = 1'b0;
  int unsigned hold_left = 0;

  // transcoder state as seen from outside
  logic [7:0] text_cap = CAP_RESET;
  logic [1:0] txt_mode = MODE_LATIN1;
  logic       txt_be = 1'b0;
  logic       half_pending = 1'b0;
  logic [7:0] held = 8'd0;
  logic       mark_window = 1'b1;
  logic       halted = 1'b0;
  logic [7:0] written = 8'd0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void push_text(input logic [7:0] ch, input logic term);
    utf8_beat_t r;
    r.ch = ch;
    r.term = term;
    r.ends_run = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic int unsigned byte_room();
    return (text_cap == 8'd0) ? 0 : text_cap - 1;
  endfunction

  function automatic void put_code_point(input logic [15:0] cp);
    int unsigned len;
    len = (cp < 16'h0080) ? 1 : ((cp < 16'h0800) ? 2 : 3);
    if (written + len > byte_room()) return;
    case (len)
      1: push_text(cp[7:0], 1'b0);
      2: begin
        push_text({3'b110, cp[10:6]}, 1'b0);
        push_text({2'b10, cp[5:0]}, 1'b0);
      end
      default: begin
        push_text({4'b1110, cp[15:12]}, 1'b0);
        push_text({2'b10, cp[11:6]}, 1'b0);
        push_text({2'b10, cp[5:0]}, 1'b0);
      end
    endcase
    written = written + len[7:0];
  endfunction

  function automatic void take_text_byte(input logic [7:0] b);
    logic [15:0] unit;
    if (txt_mode == MODE_U16_BOM || txt_mode == MODE_U16_BE) begin
      if (!half_pending) begin
        held = b;
        half_pending = 1'b1;
        return;
      end
      half_pending = 1'b0;
      if (txt_mode == MODE_U16_BOM && mark_window) begin
        mark_window = 1'b0;
        if (held == BOM_HI && b == BOM_LO) begin
          txt_be = 1'b0;
          return;
        end
        if (held == BOM_LO && b == BOM_HI) begin
          txt_be = 1'b1;
          return;
        end
      end
      mark_window = 1'b0;
      unit = txt_be ? {held, b} : {b, held};
      if (unit == 16'h0000) halted = 1'b1;
      else put_code_point(unit);
    end else if (txt_mode == MODE_UTF8) begin
      if (b == 8'h00 || written >= byte_room()) begin
        halted = 1'b1;
      end else begin
        push_text(b, 1'b0);
        written = written + 8'd1;
      end
    end else if (b == 8'h00) begin
      halted = 1'b1;
    end else begin
      put_code_point({8'h00, b});
    end
  endfunction

  function automatic void transcode_beat(input text_beat_t tb);
    step_out.delete();
    if (tb.first_mark) begin
      case (tb.enc)
        ENC_U16_BOM: txt_mode = MODE_U16_BOM;
        ENC_U16_BE:  txt_mode = MODE_U16_BE;
        ENC_UTF8:    txt_mode = MODE_UTF8;
        default:     txt_mode = MODE_LATIN1;
      endcase
      txt_be = (tb.enc == ENC_U16_BE);
      half_pending = 1'b0;
      held = 8'd0;
      mark_window = 1'b1;
      halted = 1'b0;
      written = 8'd0;
    end
    if (tb.has_byte && !halted) take_text_byte(tb.body_byte);
    if (tb.last_mark) begin
      half_pending = 1'b0;
      halted = 1'b1;
      push_text(8'h00, 1'b1);
    end
    if (step_out.size() != 0) step_out[step_out.size() - 1].ends_run = 1'b1;
    foreach (step_out[i]) utf8_due.push_back(step_out[i]);
  endfunction

  always @(posedge clk) begin : check_utf8
    utf8_beat_t want;
    in_fire <= in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (utf8_due.size() == 0) begin
          $error("out_byte: expected nothing, got %h", out_byte);
          mismatches++;
        end else begin
          want = utf8_due.pop_front();
          if (out_byte !== want.ch) begin
            $error("out_byte: expected %h, got %h", want.ch, out_byte);
            mismatches++;
          end
          if (out_is_terminator !== want.term) begin
            $error("out_is_terminator: expected %b, got %b", want.term, out_is_terminator);
            mismatches++;
          end
          if (out_run_last !== want.ends_run) begin
            $error("out_run_last: expected %b, got %b", want.ends_run, out_run_last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        transcode_beat('{in_encoding, in_data_byte, in_has_byte, in_first_byte, in_last_byte});
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin : drive_beats
    text_beat_t nxt;
    if (!in_valid || in_fire) begin
      if (rst_n && text_beats_pending.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = text_beats_pending.pop_front();
        in_valid <= 1'b1;
        in_encoding <= nxt.enc;
        in_data_byte <= nxt.body_byte;
        in_has_byte <= nxt.has_byte;
        in_first_byte <= nxt.first_mark;
        in_last_byte <= nxt.last_mark;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (want_long_hold && !long_hold_done) begin
      hold_left = LONG_HOLD_CYCLES;
      long_hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic queue_beat(input logic [7:0] enc, input logic [7:0] b, input logic has,
                            input logic first, input logic last);
    text_beats_pending.push_back('{enc, b, has, first, last});
    beats_queued++;
  endtask

  function automatic logic [15:0] random_unit();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom_range(1, 16'h007F));
      4, 5:       return 16'($urandom_range(16'h0080, 16'h07FF));
      6, 7:       return 16'($urandom_range(16'h0800, 16'hFFFF));
      8:          return 16'($urandom);
      default:    return ($urandom_range(0, 3) == 0) ? 16'h0000 :
                         16'($urandom_range(1, 16'h007F));
    endcase
  endfunction

  function automatic logic [7:0] random_text_byte();
    return ($urandom_range(0, 24) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
  endfunction

  task automatic queue_random_body();
    logic [7:0] enc;
    logic [7:0] raw[$];
    logic [15:0] unit;
    logic be;
    int unsigned pick;
    int unsigned ending;
    pick = $urandom_range(0, 19);
    if (pick == 0) enc = 8'($urandom_range(4, 255));
    else if (pick < 4) enc = ENC_LATIN1;
    else if (pick < 10) enc = ENC_U16_BOM;
    else if (pick < 14) enc = ENC_U16_BE;
    else if (pick < 19) enc = ENC_UTF8;
    else enc = 8'($urandom);
    if (enc == ENC_U16_BOM || enc == ENC_U16_BE) begin
      be = (enc == ENC_U16_BE);
      if (enc == ENC_U16_BOM && $urandom_range(0, 3) != 0) begin
        be = 1'($urandom_range(0, 1));
        raw.push_back(be ? BOM_LO : BOM_HI);
        raw.push_back(be ? BOM_HI : BOM_LO);
      end
      repeat ($urandom_range(0, 8)) begin
        unit = random_unit();
        if (be) begin
          raw.push_back(unit[15:8]);
          raw.push_back(unit[7:0]);
        end else begin
          raw.push_back(unit[7:0]);
          raw.push_back(unit[15:8]);
        end
      end
      if ($urandom_range(0, 5) == 0) raw.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 14)) raw.push_back(random_text_byte());
    end
    ending = $urandom_range(0, 9);
    if (raw.size() == 0) begin
      queue_beat(enc, 8'($urandom), 1'b0, 1'b1, 1'b1);
    end else begin
      foreach (raw[i]) begin
        if (i != 0 && $urandom_range(0, 9) == 0)
          queue_beat(8'($urandom), 8'($urandom), 1'b0, 1'b0, 1'b0);
        queue_beat((i == 0) ? enc : 8'($urandom), raw[i], 1'b1, i == 0,
                   (i == raw.size() - 1) && ending > 1);
      end
      if (ending == 1) queue_beat(8'($urandom), 8'($urandom), 1'b0, 1'b0, 1'b1);
    end
  endtask

  task automatic drain_and_settle();
    while (text_beats_pending.size() != 0 || in_valid || utf8_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [7:0] cap);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    text_cap = cap;
  endtask

  task automatic random_segment(input logic [7:0] cap, input int unsigned snd,
                                input int unsigned rcv, input logic hold);
    int unsigned start;
    drain_and_settle();
    set_capacity(cap);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    start = beats_queued;
    while (beats_queued - start < SEGMENT_BEATS) begin
      if ($urandom_range(0, 9) == 0)
        queue_beat(8'($urandom), 8'($urandom), 1'($urandom), $urandom_range(0, 3) == 0,
                   $urandom_range(0, 3) == 0);
      else
        queue_random_body();
    end
    if (hold) want_long_hold = 1'b1;
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 23;
    recv_idle_pct = 61;

    // beats ahead of any body start run as Latin-1
    queue_beat(ENC_UTF8, 8'hC3, 1'b1, 1'b0, 1'b0);
    queue_beat(ENC_LATIN1, 8'h41, 1'b1, 1'b0, 1'b1);
    // after the end: bytes are dropped, each end marker still closes
    queue_beat(ENC_LATIN1, 8'h42, 1'b1, 1'b0, 1'b0);
    queue_beat(ENC_LATIN1, 8'h00, 1'b0, 1'b0, 1'b1);
    queue_beat(ENC_LATIN1, 8'h00, 1'b0, 1'b1, 1'b1);
    queue_beat(8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0);
    queue_beat(ENC_LATIN1, 8'h00, 1'b1, 1'b0, 1'b0);
    queue_beat(ENC_LATIN1, 8'h7F, 1'b1, 1'b0, 1'b1);
    // little-endian mark, three-byte char, odd trailing byte
    queue_beat(ENC_U16_BOM, BOM_HI, 1'b1, 1'b1, 1'b0);
    queue_beat(ENC_LATIN1, BOM_LO, 1'b1, 1'b0, 1'b0);
    queue_beat(ENC_LATIN1, 8'h00, 1'b1, 1'b0, 1'b0);
    queue_beat(ENC_LATIN1, 8'h08, 1'b1, 1'b0, 1'b0);
    queue_beat(ENC_LATIN1, 8'h7A, 1'b1, 1'b0, 1'b1);
    queue_beat(ENC_U16_BOM, BOM_LO, 1'b1, 1'b1, 1'b0);
    queue_beat(ENC_LATIN1, BOM_HI, 1'b1, 1'b0, 1'b0);
    queue_beat(ENC_LATIN1, 8'hFF, 1'b1, 1'b0, 1'b0);
    queue_beat(ENC_LATIN1, 8'hFF, 1'b1, 1'b0, 1'b1);
    // mark in the second pair is text
    queue_beat(ENC_U16_BOM, 8'h41, 1'b1, 1'b1, 1'b0);
    queue_beat(ENC_LATIN1, 8'h00, 1'b1, 1'b0, 1'b0);
    queue_beat(ENC_LATIN1, BOM_HI, 1'b1, 1'b0, 1'b0);
    queue_beat(ENC_LATIN1, BOM_LO, 1'b1, 1'b0, 1'b1);
    queue_beat(ENC_U16_BE, 8'h80, 1'b1, 1'b1, 1'b0);
    queue_beat(ENC_LATIN1, 8'h00, 1'b1, 1'b0, 1'b0);
    queue_beat(ENC_LATIN1, 8'h00, 1'b1, 1'b0, 1'b0);
    queue_beat(ENC_LATIN1, 8'h00, 1'b1, 1'b0, 1'b1);
    queue_beat(ENC_UTF8, 8'hE2, 1'b1, 1'b1, 1'b0);
    queue_beat(ENC_LATIN1, 8'h00, 1'b1, 1'b0, 1'b0);
    queue_beat(ENC_LATIN1, 8'h41, 1'b1, 1'b0, 1'b1);
    drain_and_settle();
    set_capacity(8'd1);
    queue_beat(ENC_LATIN1, 8'h41, 1'b1, 1'b1, 1'b1);

    random_segment(8'd5, 23, 61, 1'b0);
    random_segment(8'd255, 23, 61, 1'b0);
    random_segment(8'd3, 61, 23, 1'b0);
    random_segment(8'd40, 61, 23, 1'b0);
    random_segment(8'd12, 0, 0, 1'b1);
    random_segment(8'd2, 0, 0, 1'b0);
    drain_and_settle();

    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: id3_text_to_utf8_unit.f
design/id3tu_pkg.sv
design/id3tu_front.sv
design/id3tu_queue.sv
design/id3tu_back.sv
design/id3_text_to_utf8_unit.sv
tb/id3_text_to_utf8_unit_test.sv
